// ----- hw/rtl/igb_pkg.sv -----
`default_nettype none

package igb_pkg;

  localparam int ANGLE_FRAC_BITS   = 28;
  localparam int CORDIC_ITERATIONS = 30;
  localparam int ITER = (CORDIC_ITERATIONS > 62) ? 62 : CORDIC_ITERATIONS;
  localparam int ANG_SH = 61 - ANGLE_FRAC_BITS;

  localparam logic signed [63:0] PI_Q61         = 64'sh6487ED5110B4611A;
  localparam logic signed [63:0] HALF_PI_Q61    = 64'sh3243F6A8885A308D;
  localparam logic signed [63:0] QUARTER_PI_Q61 = 64'sh1921FB54442D1847;
  localparam logic signed [63:0] PI_F_64        = PI_Q61 >>> ANG_SH;
  localparam logic signed [31:0] PI_F           = 32'(PI_F_64);
  localparam logic signed [31:0] TWO_PI_F       = 32'(2 * PI_F_64);
  localparam logic signed [33:0] GAIN_Q30       = 34'sd652032874;

  function automatic logic [63:0] pow2_div(input int n, input int d);
    logic [63:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 61; b >= 0; b--) begin
      rem = {rem[62:0], (b == n)};
      if (rem >= 64'(d)) begin
        rem  = rem - 64'(d);
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [63:0] atan_q61(input int i);
    logic signed [63:0] sum;
    logic signed [63:0] t;
    sum = '0;
    if (i == 0) begin
      sum = QUARTER_PI_Q61;
    end else begin
      for (int k = 0; k < 31; k++) begin
        if (i * (2 * k + 1) <= 61) begin
          t   = signed'(pow2_div(61 - i * (2 * k + 1), 2 * k + 1));
          sum = (k % 2 == 1) ? sum - t : sum + t;
        end
      end
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/initial_bearing_between_points.sv -----
// Throughput: one transfer per cycle unless a stalled result holds the pipeline;
// every CORDIC micro-rotation is its own register stage.
// A result held under out_stall freezes the whole pipeline, and in_stall follows it.
// Reset (rst_n low, synchronous) clears every stage valid bit; data registers are not reset.
`default_nettype none

module initial_bearing_between_points import igb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [29:0] in_start_latitude,
  input  wire logic signed [30:0] in_start_longitude,
  input  wire logic signed [29:0] in_end_latitude,
  input  wire logic signed [30:0] in_end_longitude,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [30:0]      out_bearing
);

  localparam int LAT = 2 * ITER + 11;

  logic           en;
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;

  assign en       = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !en;
  assign vld_nxt  = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  logic signed [29:0] s1_lat1_r, s1_lat2_r, s2_lat1_r, s2_lat2_r;
  logic signed [29:0] s3_lat1_r, s3_lat2_r, s4_lat1_r, s4_lat2_r;
  logic signed [30:0] s1_lon1_r, s1_lon2_r;
  logic signed [31:0] s2_dl_r, s3_dl_r, s4_dl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_lat1_r <= in_start_latitude;
      s1_lat2_r <= in_end_latitude;
      s1_lon1_r <= in_start_longitude;
      s1_lon2_r <= in_end_longitude;
      s2_lat1_r <= s1_lat1_r;
      s2_lat2_r <= s1_lat2_r;
      s2_dl_r   <= 32'(s1_lon2_r) - 32'(s1_lon1_r);
      s3_lat1_r <= s2_lat1_r;
      s3_lat2_r <= s2_lat2_r;
      if (s2_dl_r >= TWO_PI_F) begin
        s3_dl_r <= s2_dl_r - TWO_PI_F;
      end else if (s2_dl_r <= -TWO_PI_F) begin
        s3_dl_r <= s2_dl_r + TWO_PI_F;
      end else begin
        s3_dl_r <= s2_dl_r;
      end
      s4_lat1_r <= s3_lat1_r;
      s4_lat2_r <= s3_lat2_r;
      if (s3_dl_r > PI_F) begin
        s4_dl_r <= s3_dl_r - TWO_PI_F;
      end else if (s3_dl_r < -PI_F) begin
        s4_dl_r <= s3_dl_r + TWO_PI_F;
      end else begin
        s4_dl_r <= s3_dl_r;
      end
    end
  end

  logic signed [31:0] ang [0:2];
  logic signed [33:0] rx_r [0:ITER][0:2];
  logic signed [33:0] ry_r [0:ITER][0:2];
  logic signed [63:0] rz_r [0:ITER][0:2];
  logic               rneg_r [0:ITER][0:2];

  assign ang[0] = 32'(s4_lat1_r);
  assign ang[1] = 32'(s4_lat2_r);
  assign ang[2] = s4_dl_r;

  for (genvar l = 0; l < 3; l++) begin : g_entry
    logic signed [63:0] zq;
    logic signed [63:0] zf;
    logic               nf;

    always_comb begin
      zq = 64'(ang[l]) <<< ANG_SH;
      zf = zq;
      nf = 1'b0;
      if (zq > HALF_PI_Q61) begin
        zf = zq - PI_Q61;
        nf = 1'b1;
      end else if (zq < -HALF_PI_Q61) begin
        zf = zq + PI_Q61;
        nf = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[0][l]   <= GAIN_Q30;
        ry_r[0][l]   <= '0;
        rz_r[0][l]   <= zf;
        rneg_r[0][l] <= nf;
      end
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_rot
    localparam logic signed [63:0] TAB = atan_q61(i);
    for (genvar l = 0; l < 3; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (en) begin
          rneg_r[i+1][l] <= rneg_r[i][l];
          if (rz_r[i][l] >= 0) begin
            rx_r[i+1][l] <= rx_r[i][l] - (ry_r[i][l] >>> i);
            ry_r[i+1][l] <= ry_r[i][l] + (rx_r[i][l] >>> i);
            rz_r[i+1][l] <= rz_r[i][l] - TAB;
          end else begin
            rx_r[i+1][l] <= rx_r[i][l] + (ry_r[i][l] >>> i);
            ry_r[i+1][l] <= ry_r[i][l] - (rx_r[i][l] >>> i);
            rz_r[i+1][l] <= rz_r[i][l] + TAB;
          end
        end
      end
    end
  end

  logic signed [33:0] c1, s1, c2, s2, cd, sd;
  logic signed [63:0] m1_p1_r, m1_p2_r, m1_p3_r;
  logic signed [33:0] m1_cd_r;
  logic signed [63:0] m2_p1_r, m2_p2_r, m2_q_r;
  logic signed [63:0] m3_x_r, m3_y_r;

  assign c1 = rneg_r[ITER][0] ? -rx_r[ITER][0] : rx_r[ITER][0];
  assign s1 = rneg_r[ITER][0] ? -ry_r[ITER][0] : ry_r[ITER][0];
  assign c2 = rneg_r[ITER][1] ? -rx_r[ITER][1] : rx_r[ITER][1];
  assign s2 = rneg_r[ITER][1] ? -ry_r[ITER][1] : ry_r[ITER][1];
  assign cd = rneg_r[ITER][2] ? -rx_r[ITER][2] : rx_r[ITER][2];
  assign sd = rneg_r[ITER][2] ? -ry_r[ITER][2] : ry_r[ITER][2];

  always_ff @(posedge clk) begin
    if (en) begin
      m1_p1_r <= 64'(sd) * 64'(c2);
      m1_p2_r <= 64'(c1) * 64'(s2);
      m1_p3_r <= 64'(s1) * 64'(c2);
      m1_cd_r <= cd;
      m2_p1_r <= m1_p1_r;
      m2_p2_r <= m1_p2_r;
      m2_q_r  <= 64'(34'(m1_p3_r >>> 30)) * 64'(m1_cd_r);
      m3_y_r  <= m2_p1_r;
      m3_x_r  <= m2_p2_r - m2_q_r;
    end
  end

  logic signed [63:0] vx_r [0:ITER];
  logic signed [63:0] vy_r [0:ITER];
  logic signed [63:0] vw_r [0:ITER];
  logic signed [31:0] vb_r [0:ITER];
  logic               vz_r [0:ITER];

  always_ff @(posedge clk) begin
    if (en) begin
      vw_r[0] <= '0;
      vz_r[0] <= (m3_x_r == 0) && (m3_y_r == 0);
      if (m3_x_r < 0) begin
        vx_r[0] <= -m3_x_r;
        vy_r[0] <= -m3_y_r;
        vb_r[0] <= (m3_y_r >= 0) ? PI_F : -PI_F;
      end else begin
        vx_r[0] <= m3_x_r;
        vy_r[0] <= m3_y_r;
        vb_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_vec
    localparam logic signed [63:0] TAB = atan_q61(i);
    always_ff @(posedge clk) begin
      if (en) begin
        vb_r[i+1] <= vb_r[i];
        vz_r[i+1] <= vz_r[i];
        if (vy_r[i] >= 0) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          vw_r[i+1] <= vw_r[i] + TAB;
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          vw_r[i+1] <= vw_r[i] - TAB;
        end
      end
    end
  end

  localparam logic signed [63:0] RND = 64'sd1 <<< (ANG_SH - 1);

  logic signed [31:0] f1_r_r;
  logic               f1_zero_r;
  logic signed [30:0] bearing_r;

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r_r    <= vb_r[ITER] + 32'((vw_r[ITER] + RND) >>> ANG_SH);
      f1_zero_r <= vz_r[ITER];
      if (f1_zero_r) begin
        bearing_r <= '0;
      end else if (f1_r_r <= -PI_F) begin
        bearing_r <= 31'(f1_r_r + TWO_PI_F);
      end else if (f1_r_r > PI_F) begin
        bearing_r <= 31'(f1_r_r - TWO_PI_F);
      end else begin
        bearing_r <= 31'(f1_r_r);
      end
    end
  end

  assign out_valid   = vld_r[LAT-1];
  assign out_bearing = bearing_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_bearing) > -PI_F) && (32'(out_bearing) <= PI_F))
    else $error("bearing outside (-pi, pi]");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(vld_r))
    else $error("pipeline moved while result stalled");

  a_accept_flows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("transfer lost at pipeline entry");

endmodule

`default_nettype wire

// ----- bench/igb_checker.sv -----
`default_nettype none

module igb_checker import igb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic signed [29:0] in_start_latitude,
  input  wire logic signed [30:0] in_start_longitude,
  input  wire logic signed [29:0] in_end_latitude,
  input  wire logic signed [30:0] in_end_longitude,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [30:0] out_bearing,
  output int                      mismatch_count,
  output int                      bearings_pending
);

  localparam longint PIF = longint'(PI_Q61) >>> ANG_SH;

  longint atan_q61_tab[62];
  logic signed [30:0] bearing_q[$];

  initial begin
    longint sum;
    longint term;
    int k;
    int e;
    atan_q61_tab[0] = QUARTER_PI_Q61;
    for (int i = 1; i < 62; i++) begin
      sum = 0;
      k = 0;
      e = i;
      while (e <= 61) begin
        term = longint'((64'd1 << (61 - e)) / longint'(unsigned'(2 * k + 1)));
        sum = (k % 2 == 1) ? sum - term : sum + term;
        k++;
        e = i * (2 * k + 1);
      end
      atan_q61_tab[i] = sum;
    end
  end

  function automatic void sin_cos_q30(input longint ang, output longint s, output longint c);
    longint r;
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit flip;
    flip = 0;
    r = ang % (2 * PIF);
    if (r > PIF) r -= 2 * PIF;
    else if (r < -PIF) r += 2 * PIF;
    z = r * (64'sd1 <<< ANG_SH);
    if (z > longint'(PI_Q61) / 2) begin
      z -= PI_Q61;
      flip = 1;
    end else if (z < -(longint'(PI_Q61) / 2)) begin
      z += PI_Q61;
      flip = 1;
    end
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_q61_tab[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_q61_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint atan2_angle(input longint y_in, input longint x_in);
    longint x;
    longint y;
    longint w;
    longint base;
    longint r;
    longint dx;
    longint dy;
    x = x_in;
    y = y_in;
    w = 0;
    base = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      base = (y >= 0) ? PIF : -PIF;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        w += atan_q61_tab[i];
      end else begin
        x -= dx;
        y += dy;
        w -= atan_q61_tab[i];
      end
    end
    r = base + ((w + (64'sd1 <<< (ANG_SH - 1))) >>> ANG_SH);
    if (r <= -PIF) r += 2 * PIF;
    else if (r > PIF) r -= 2 * PIF;
    return r;
  endfunction

  function automatic logic signed [30:0] predict_bearing(input longint lat1, input longint lon1,
                                                         input longint lat2, input longint lon2);
    longint s1, c1, s2, c2, sd, cd, yv, xv;
    sin_cos_q30(lat1, s1, c1);
    sin_cos_q30(lat2, s2, c2);
    sin_cos_q30(lon2 - lon1, sd, cd);
    yv = sd * c2;
    xv = c1 * s2 - ((s1 * c2) >>> 30) * cd;
    return 31'(atan2_angle(yv, xv));
  endfunction

  assign bearings_pending = bearing_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      bearing_q.delete();
      mismatch_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        bearing_q.push_back(predict_bearing(in_start_latitude, in_start_longitude,
                                            in_end_latitude, in_end_longitude));
      if (out_valid && !out_stall) begin
        if (bearing_q.size() == 0) begin
          $error("bearing: unexpected transfer, actual %0d", out_bearing);
          mismatch_count <= mismatch_count + 1;
        end else begin
          if (out_bearing !== bearing_q[0]) begin
            $error("bearing: expected %0d, actual %0d", bearing_q[0], out_bearing);
            mismatch_count <= mismatch_count + 1;
          end
          void'(bearing_q.pop_front());
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb_initial_bearing_between_points.sv -----
`default_nettype none

module tb_initial_bearing_between_points;
  import igb_pkg::*;

  localparam int LAT_MAX = 421657428;
  localparam int LON_MAX = 843314857;
  localparam int WATCHDOG_LIMIT = 5000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [29:0] in_start_latitude = '0;
  logic signed [30:0] in_start_longitude = '0;
  logic signed [29:0] in_end_latitude = '0;
  logic signed [30:0] in_end_longitude = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [30:0] out_bearing;

  int mismatch_count;
  int bearings_pending;
  int send_idle_pct = 18;
  int recv_idle_pct = 84;
  logic long_hold_req = 0;
  bit long_hold_used = 0;
  int long_hold_left = 0;
  int idle_cycles = 0;

  initial forever #2 clk = ~clk;

  initial_bearing_between_points i_dut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_start_latitude, .in_start_longitude, .in_end_latitude, .in_end_longitude,
    .out_valid, .out_stall, .out_bearing
  );

  igb_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_start_latitude, .in_start_longitude, .in_end_latitude, .in_end_longitude,
    .out_valid, .out_stall, .out_bearing, .mismatch_count, .bearings_pending
  );

  // receiver: random stalls, plus one long hold-off
  always @(posedge clk) begin
    if (long_hold_req && !long_hold_used) begin
      long_hold_used = 1;
      long_hold_left = 400;
    end
    if (long_hold_left > 0) begin
      long_hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic transfer_points(input logic [29:0] lat1, input logic [30:0] lon1,
                                 input logic [29:0] lat2, input logic [30:0] lon2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_latitude <= lat1;
    in_start_longitude <= lon1;
    in_end_latitude <= lat2;
    in_end_longitude <= lon2;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  function automatic logic [29:0] rand_lat();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 30'($urandom);
    if (sel == 1) return ($urandom_range(1)) ? 30'(LAT_MAX) : 30'(-LAT_MAX);
    return 30'(int'($urandom_range(2 * LAT_MAX)) - LAT_MAX);
  endfunction

  function automatic logic [30:0] rand_lon();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 31'($urandom);
    if (sel == 1) return ($urandom_range(1)) ? 31'(LON_MAX) : 31'(-LON_MAX);
    return 31'(longint'($urandom_range(2 * LON_MAX)) - LON_MAX);
  endfunction

  task automatic send_random(input int count);
    logic [29:0] lat;
    logic [30:0] lon;
    for (int n = 0; n < count; n++) begin
      lat = rand_lat();
      lon = rand_lon();
      case ($urandom_range(7))
        0: transfer_points(lat, lon, lat, lon);
        1: transfer_points(lat, lon, -lat, lon + 31'(LON_MAX));
        2: transfer_points(lat, lon, rand_lat(), lon);
        default: transfer_points(lat, lon, rand_lat(), rand_lon());
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    transfer_points('0, '0, '0, '0);
    transfer_points(30'(LAT_MAX), '0, 30'(-LAT_MAX), '0);
    transfer_points(30'(-LAT_MAX), '0, 30'(LAT_MAX), '0);
    transfer_points('0, 31'(-LON_MAX), '0, 31'(LON_MAX));
    transfer_points('0, 31'(LON_MAX), '0, 31'(-LON_MAX));
    transfer_points('0, '0, '0, 31'(LON_MAX));
    transfer_points('0, '0, '0, 31'(-LON_MAX));
    transfer_points(30'(LAT_MAX), 31'(LON_MAX), 30'(LAT_MAX), 31'(LON_MAX));
    transfer_points('0, '0, 30'(1), '0);
    transfer_points('0, '0, 30'(-1), '0);
    transfer_points('0, '0, '0, 31'(1));
    transfer_points('0, '0, '0, 31'(-1));
    transfer_points(30'(LAT_MAX / 2), '0, 30'(-LAT_MAX / 2), 31'(LON_MAX));
    transfer_points(30'(LAT_MAX / 2), '0, 30'(LAT_MAX / 4), 31'(LON_MAX));
    transfer_points(30'(LAT_MAX / 2), '0, 30'(LAT_MAX / 2), 31'(-LON_MAX / 2));
    transfer_points({1'b1, 29'd0}, {1'b1, 30'd0}, {1'b1, 29'd0}, {1'b1, 30'd0});
    transfer_points({1'b0, {29{1'b1}}}, {1'b0, {30{1'b1}}}, {30{1'b1}}, {31{1'b1}});
    transfer_points({30{1'b1}}, {31{1'b1}}, {1'b0, {29{1'b1}}}, {1'b0, {30{1'b1}}});

    send_random(100);
    long_hold_req <= 1'b1;
    send_random(300);
    send_idle_pct = 84;
    recv_idle_pct = 18;
    send_random(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(400);
    in_valid <= 1'b0;

    while (bearings_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
